>>> sv/pwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared types and constants for the packed weight dequantizer.
// ----------------------------------------------------------------------------
package pwd_pkg;

   localparam logic [1:0] MODE_2BIT  = 2'd0;
   localparam logic [1:0] MODE_4BIT  = 2'd1;
   localparam logic [1:0] MODE_8BIT  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as 8-bit

   // one weight on its way through the multiply pipeline
   typedef struct packed {
      logic        valid;
      logic        last;
      logic        sign;
      logic        special;
      logic [15:0] special_val;
      logic [19:0] prod;
      logic [5:0]  expo;   // exponent offset: e = expo - 25
   } mul_stage_type;

endpackage

>>> sv/pwd_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwd_encode
// Three-stage rounding of sign * p * 2^(expo-25) to binary16.
// ----------------------------------------------------------------------------
module pwd_encode (
   input  logic                   clock,
   input  logic                   reset,
   input  pwd_pkg::mul_stage_type in_stage,
   output logic                   out_valid,
   output logic                   out_last,
   output logic [15:0]            out_value
);

   // stage A: leading one position and shift amount
   pwd_pkg::mul_stage_type a_ff;
   logic [5:0] a_sh_ff, a_sh_in;   // signed-ish: shift + 16 bias
   logic [4:0] lead;

   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 20; i++) begin
         if (in_stage.prod[i]) lead = 5'(i);
      end
   end

   always_comb begin
      logic signed [7:0] sh;
      logic signed [7:0] mn;
      sh = $signed({3'd0, lead}) - 8'sd10;
      // -24 - e = 1 - expo
      mn = 8'sd1 - $signed({2'd0, in_stage.expo});
      if (mn > sh) sh = mn;
      a_sh_in = 6'(sh + 8'sd16);
   end

   // stage B: shift and round
   logic        b_valid_ff, b_last_ff, b_sign_ff, b_special_ff, b_zero_ff;
   logic [15:0] b_special_val_ff;
   logic [11:0] b_q_ff, b_q_in;
   logic [6:0]  b_ex_ff, b_ex_in;

   always_comb begin
      logic [19:0] rem;
      logic [19:0] half;
      logic [19:0] q;
      logic signed [7:0] sh;
      sh = $signed({2'd0, a_sh_ff}) - 8'sd16;
      rem = '0;
      half = '0;
      if (sh > 0) begin
         q = a_ff.prod >> sh[4:0];
         rem = a_ff.prod & ((20'd1 << sh[4:0]) - 20'd1);
         half = 20'd1 << (sh[4:0] - 5'd1);
         if (rem > half || (rem == half && q[0])) q = q + 20'd1;
      end else begin
         q = a_ff.prod << 5'(-sh);
      end
      b_q_in = q[11:0];
      // ex = e + sh + 25 = expo + sh
      b_ex_in = 7'($signed({2'd0, a_ff.expo}) + sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_valid_ff <= 1'b0;
         out_valid  <= 1'b0;
      end else begin
         a_ff.valid <= in_stage.valid;
         b_valid_ff <= a_ff.valid;
         out_valid  <= b_valid_ff;
      end
      a_ff.last        <= in_stage.last;
      a_ff.sign        <= in_stage.sign;
      a_ff.special     <= in_stage.special;
      a_ff.special_val <= in_stage.special_val;
      a_ff.prod        <= in_stage.prod;
      a_ff.expo        <= in_stage.expo;
      a_sh_ff          <= a_sh_in;
      b_last_ff        <= a_ff.last;
      b_sign_ff        <= a_ff.sign;
      b_special_ff     <= a_ff.special;
      b_special_val_ff <= a_ff.special_val;
      b_zero_ff        <= (a_ff.prod == 20'd0);
      b_q_ff           <= b_q_in;
      b_ex_ff          <= b_ex_in;
   end

   // stage C: renormalize and pack
   logic [15:0] c_value_in;
   always_comb begin
      logic [11:0] q;
      logic signed [7:0] ex;
      q  = b_q_ff;
      ex = $signed({b_ex_ff[6], b_ex_ff});
      if (q >= 12'd2048) begin
         q  = q >> 1;
         ex = ex + 8'sd1;
      end
      if (b_special_ff)        c_value_in = b_special_val_ff;
      else if (b_zero_ff)      c_value_in = {b_sign_ff, 15'd0};
      else if (q < 12'd1024)   c_value_in = {b_sign_ff, 5'd0, q[9:0]};
      else if (ex >= 8'sd31)   c_value_in = {b_sign_ff, 15'h7C00};
      else                     c_value_in = {b_sign_ff, ex[4:0], q[9:0]};
   end

   always_ff @(posedge clock) begin
      out_last  <= b_last_ff;
      out_value <= c_value_in;
   end

endmodule

>>> sv/packed_weight_dequantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_weight_dequantizer
// Unpacks quantized weights from a 32-bit word and scales them to binary16.
// ----------------------------------------------------------------------------
//  channel  | ports                        | transfer
//  ---------+------------------------------+-------------------------------
//  request  | req_* fields, start, busy    | start high and busy low
//  response | rsp_weight_value, rsp_last   | rsp_valid high, one cycle each
//  config   | csr_we, csr_bits_mode        | csr_we high
//
// A word yields 32/bits results, one per cycle: 16, 8 or 4 results per word,
// set by the unpack sequencer that issues one weight a cycle. busy is high
// while a word is being unpacked, except on its final weight, so the next word
// enters right behind it. Each weight passes stage 1, stage 2 and encode A, B, C.
// The receiver cannot stall; the pipeline never holds. Reset clears valid
// bits and sets the width mode to 4 bits.
module packed_weight_dequantizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_weight_word,
   input  logic [31:0] req_zero_word,
   input  logic [3:0]  req_zero_slot,
   input  logic [15:0] req_scale_bits,
   output logic        rsp_valid,
   output logic [15:0] rsp_weight_value,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_bits_mode
);

   logic [1:0] mode_ff;
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= pwd_pkg::MODE_4BIT;
      else if (csr_we) mode_ff <= csr_bits_mode;
   end

   // field geometry for the current mode
   logic [3:0] count_m1;
   logic [7:0] mask;
   always_comb begin
      case (mode_ff)
         pwd_pkg::MODE_2BIT: begin count_m1 = 4'd15; mask = 8'h03; end
         pwd_pkg::MODE_4BIT: begin count_m1 = 4'd7;  mask = 8'h0F; end
         default:            begin count_m1 = 4'd3;  mask = 8'hFF; end
      endcase
   end

   function automatic logic [7:0] field_at(input logic [31:0] w, input logic [1:0] m,
                                            input logic [3:0] j);
      logic [7:0] r;
      case (m)
         pwd_pkg::MODE_2BIT: r = 8'(w >> {j, 1'b0});
         pwd_pkg::MODE_4BIT: r = 8'(w >> {j[2:0], 2'b0});
         default:            r = 8'(w >> {j[1:0], 3'b0});
      endcase
      return r;
   endfunction

   // sequencer: hold the word, advance one field a cycle
   logic        act_ff;
   logic [3:0]  idx_ff;
   logic [31:0] word_ff;
   logic [8:0]  zero_ff;
   logic [15:0] scale_ff;
   logic        take;
   logic        fin;

   assign fin  = act_ff && (idx_ff == count_m1);
   assign busy = act_ff && !fin;
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         idx_ff <= 4'd0;
      end else if (take) begin
         act_ff <= 1'b1;
         idx_ff <= 4'd0;
      end else if (fin) begin
         act_ff <= 1'b0;
      end else if (act_ff) begin
         idx_ff <= idx_ff + 4'd1;
      end
      if (take) begin
         word_ff  <= req_weight_word;
         scale_ff <= req_scale_bits;
         zero_ff  <= {1'b0, field_at(req_zero_word, mode_ff, req_zero_slot & count_m1)
                     & mask} + 9'd1;
      end
   end

   // stage 1: signed difference, scale passed along
   logic        s1_valid_ff, s1_last_ff;
   logic [9:0]  s1_diff_ff;   // two's complement
   logic [15:0] s1_scale_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= act_ff;
      s1_last_ff  <= fin;
      s1_diff_ff  <= {2'b0, field_at(word_ff, mode_ff, idx_ff) & mask} - {1'b0, zero_ff};
      s1_scale_ff <= scale_ff;
   end

   // stage 2: multiply mantissa by magnitude, resolve specials
   pwd_pkg::mul_stage_type m_ff, m_in;
   always_comb begin
      logic [4:0] ex;
      logic [9:0] fr;
      logic       neg;
      logic [8:0] mag;
      ex  = s1_scale_ff[14:10];
      fr  = s1_scale_ff[9:0];
      neg = s1_diff_ff[9];
      mag = neg ? 9'(-s1_diff_ff) : s1_diff_ff[8:0];
      m_in.valid = s1_valid_ff;
      m_in.last  = s1_last_ff;
      m_in.sign  = s1_scale_ff[15] ^ neg;
      m_in.special = (ex == 5'd31);
      if (fr != 10'd0)       m_in.special_val = s1_scale_ff | 16'h0200;
      else if (mag == 9'd0)  m_in.special_val = 16'h7E00;
      else                   m_in.special_val = {m_in.sign, 15'h7C00};
      if (ex == 5'd0) begin
         m_in.prod = 20'({1'b0, fr} * mag);
         m_in.expo = 6'd1;
      end else begin
         m_in.prod = 20'({1'b1, fr} * mag);
         m_in.expo = {1'b0, ex};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) m_ff.valid <= 1'b0;
      else       m_ff.valid <= m_in.valid;
      m_ff.last        <= m_in.last;
      m_ff.sign        <= m_in.sign;
      m_ff.special     <= m_in.special;
      m_ff.special_val <= m_in.special_val;
      m_ff.prod        <= m_in.prod;
      m_ff.expo        <= m_in.expo;
   end

   pwd_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (m_ff),
      .out_valid (rsp_valid),
      .out_last  (rsp_last),
      .out_value (rsp_weight_value)
   );

endmodule

>>> test/tb_packed_weight_dequantizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_weight_dequantizer
// Self-checking bench for the packed weight dequantizer. Drives words with
// random gaps across all width modes, predicts every binary16 result in a
// scoreboard class and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_packed_weight_dequantizer;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;

   typedef struct {
      logic [15:0] weight_value;
      logic        last;
   } deq_result_type;

   // Scoreboard: holds the width mode and the queue of pending weights.
   class dequant_scoreboard;
      logic [1:0]     bits_mode;
      deq_result_type pending[$];
      int             errors;

      function new();
         bits_mode = pwd_pkg::MODE_4BIT;
         errors    = 0;
      endfunction

      // Round sign * p * 2^e to binary16, nearest-even.
      function logic [15:0] round_half(logic sign, logic [31:0] p, int e);
         int msb;
         int sh;
         int ex;
         logic [31:0] q;
         logic [31:0] rem;
         logic [31:0] halfway;
         msb = 0;
         if (p == 0) return {sign, 15'd0};
         for (int i = 0; i < 32; i++) if (p[i]) msb = i;
         sh = msb - 10;
         if (-24 - e > sh) sh = -24 - e;
         if (sh > 0) begin
            rem     = p & ((32'd1 << sh) - 1);
            halfway = 32'd1 << (sh - 1);
            q       = p >> sh;
            if (rem > halfway || (rem == halfway && q[0])) q++;
         end else begin
            q = p << (-sh);
         end
         if (q >= 2048) begin
            q = q >> 1;
            sh++;
         end
         if (q < 1024) return {sign, q[14:0]};
         ex = e + sh + 25;
         if (ex >= 31) return {sign, 15'h7C00};
         return {sign, ex[4:0], q[9:0]};
      endfunction

      function logic [15:0] scale_weight(logic [15:0] scale, int diff);
         logic        sign;
         logic [4:0]  ex;
         logic [9:0]  fr;
         logic [31:0] mag;
         ex   = scale[14:10];
         fr   = scale[9:0];
         mag  = (diff < 0) ? -diff : diff;
         sign = scale[15] ^ (diff < 0);
         if (ex == 5'd31) begin
            if (fr != 0) return scale | 16'h0200;
            if (mag == 0) return 16'h7E00;
            return {sign, 15'h7C00};
         end
         if (ex == 0) return round_half(sign, fr * mag, -24);
         return round_half(sign, (32'd1024 + fr) * mag, int'(ex) - 25);
      endfunction

      function void note_word(logic [31:0] wword, logic [31:0] zword,
                              logic [3:0] slot, logic [15:0] scale);
         int b;
         int count;
         int mask;
         int zero;
         int sel;
         deq_result_type r;
         b     = (bits_mode == pwd_pkg::MODE_2BIT) ? 2 :
                 (bits_mode == pwd_pkg::MODE_4BIT) ? 4 : 8;
         count = 32 / b;
         mask  = (1 << b) - 1;
         sel   = slot & (count - 1);
         zero  = int'((zword >> (sel * b)) & mask) + 1;
         for (int j = 0; j < count; j++) begin
            r.weight_value = scale_weight(scale, int'((wword >> (j * b)) & mask) - zero);
            r.last         = (j == count - 1);
            pending = {pending, r};
         end
      endfunction

      function void check_weight(logic [15:0] value, logic last);
         deq_result_type x;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value=%h last=%b", $time, value, last);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (x.weight_value !== value) begin
            $display("%0t: weight_value expected %h actual %h", $time, x.weight_value, value);
            errors++;
         end
         if (x.last !== last) begin
            $display("%0t: last expected %b actual %b", $time, x.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_weight_word;
   logic [31:0] req_zero_word;
   logic [3:0]  req_zero_slot;
   logic [15:0] req_scale_bits;
   logic        rsp_valid;
   logic [15:0] rsp_weight_value;
   logic        rsp_last;
   logic        csr_we;
   logic [1:0]  csr_bits_mode;

   dequant_scoreboard board = new();
   int  idle_cycles;

   packed_weight_dequantizer uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_weight_word(req_weight_word), .req_zero_word(req_zero_word),
      .req_zero_slot(req_zero_slot), .req_scale_bits(req_scale_bits),
      .rsp_valid(rsp_valid), .rsp_weight_value(rsp_weight_value),
      .rsp_last(rsp_last), .csr_we(csr_we), .csr_bits_mode(csr_bits_mode)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Sample at the rising edge: note accepted words, check responses,
   // and count cycles without any transfer for the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_word(req_weight_word, req_zero_word, req_zero_slot, req_scale_bits);
         if (rsp_valid)
            board.check_weight(rsp_weight_value, rsp_last);
         if ((start && !busy) || rsp_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one word: hold start until the transfer and leave it high; a gap
   // before the word drops it first. Gap cycles are drawn per word.
   task automatic send_word(logic [31:0] w, logic [31:0] z, logic [3:0] s,
                            logic [15:0] sc, bit random_gap);
      int gap;
      gap = random_gap ? $urandom_range(0, 6) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;   // keep stretches back to back
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_weight_word <= w;
      req_zero_word   <= z;
      req_zero_slot   <= s;
      req_scale_bits  <= sc;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop start, wait until every expected weight has come, then let the
   // pipeline settle.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(logic [1:0] mode);
      drain();
      csr_bits_mode <= mode;
      csr_we        <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      board.bits_mode = mode;
   endtask

   // Random scale mostly from normal ranges, with specials mixed in.
   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 9))
         0: return {1'($urandom), 5'd31, 10'($urandom)};
         1: return {1'($urandom), 5'd31, 10'd0};
         2: return {1'($urandom), 5'd0, 10'($urandom)};
         3: return {1'($urandom), 5'($urandom_range(26, 30)), 10'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic directed_words();
      send_word(32'h0000_0000, 32'h0000_0000, 4'd0, 16'h3C00, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 16'hBC00, 1'b0);
      send_word(32'h7654_3210, 32'hFEDC_BA98, 4'd9, 16'h7BFF, 1'b0);  // overflow
      send_word(32'h1234_5678, 32'h0000_0000, 4'd0, 16'h7E01, 1'b0);  // NaN
      send_word(32'h1234_5678, 32'h0000_0000, 4'd3, 16'h7D55, 1'b0);  // signaling NaN
      send_word(32'h0123_4567, 32'h0000_0000, 4'd0, 16'h7C00, 1'b0);  // inf, zero diff
      send_word(32'h89AB_CDEF, 32'h0000_0007, 4'd0, 16'hFC00, 1'b0);
      send_word(32'hA5A5_A5A5, 32'h5A5A_5A5A, 4'd5, 16'h0001, 1'b0);  // tiny
      send_word(32'h3333_3333, 32'h2222_2222, 4'd2, 16'h0400, 1'b0);
      send_word(32'h0F0F_0F0F, 32'h0000_0000, 4'd0, 16'h8000, 1'b0);  // zero scale
      send_word(32'hFEDC_BA98, 32'h1357_9BDF, 4'd12, 16'h8001, 1'b0);
   endtask

   initial begin
      logic [1:0] modes [5];
      modes           = '{pwd_pkg::MODE_2BIT, pwd_pkg::MODE_8BIT, pwd_pkg::MODE_SPARE,
                          pwd_pkg::MODE_4BIT, pwd_pkg::MODE_2BIT};
      idle_cycles     = 0;
      reset           = 1'b1;
      start           = 1'b0;
      csr_we          = 1'b0;
      csr_bits_mode   = pwd_pkg::MODE_4BIT;
      req_weight_word = '0;
      req_zero_word   = '0;
      req_zero_slot   = '0;
      req_scale_bits  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset mode first, then each width mode, including the unused code
      directed_words();
      for (int m = 0; m < 5; m++) begin
         write_mode(modes[m]);
         directed_words();
         for (int i = 0; i < 50; i++)
            send_word($urandom, $urandom, 4'($urandom), pick_scale(), 1'b1);
         if (m == 1) drain();   // sender holds off until all results are in
      end
      drain();
      if (board.errors == 0)
         $display("tb_packed_weight_dequantizer: done, clean");
      else
         $display("tb_packed_weight_dequantizer: done, errors");
      $finish;
   end

   // Watchdog: end the run if nothing moves for too long.
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("tb_packed_weight_dequantizer: done, errors");
      $finish;
   end

endmodule
